/* design/rmst_pkg.sv */
// Package with the shared constants, codes and state type of the range minimum segment tree.
package rmst_pkg;

   localparam int LEAVES_DEFAULT = 1024;
   localparam int VALUE_WIDTH = 64;
   localparam int INDEX_WIDTH = 10;
   localparam int COUNT_WIDTH = 11;
   localparam int PADDR_WIDTH = 3;
   localparam int PDATA_WIDTH = 32;

   localparam logic [COUNT_WIDTH-1:0] N_USED_RESET = 11'd1024;
   localparam logic [VALUE_WIDTH-1:0] EMPTY_SENTINEL = 64'h3f3f_3f3f_3f3f_3f3f;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic CSR_N_USED = 1'b0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WR_STEP,
      ST_WR_MIN,
      ST_Q_LEFT,
      ST_Q_RIGHT
   } state_type;

endpackage

/* design/rmst_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module rmst_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/range_minimum_segment_tree.sv */
// Top level of the range minimum segment tree with point writes.
//
//   channel   ports                                   handshake
//   request   req_op, req_position, req_right_end,    start high while busy low
//             req_new_value
//   result    rsp_min_value                           rsp_strobe, one cycle, no stall
//   config    psel, penable, pwrite, paddr, pwdata,   APB write, pready always high
//             prdata, pready
//
// A write walks from its leaf up to the root, storing the running minimum at each level
// and folding in the sibling. A query walks up from both ends of its range, the single
// RAM read port and the shared signed comparator setting the pace.
// An empty query's sentinel result is shown in the cycle after the query is accepted;
// an ignored write is dropped and the block stays idle.
// After reset a clearing pass writes zero to all 2*LEAVES nodes, busy high throughout.
// Results are shown for one cycle on rsp_strobe; the receiver cannot stall them.
module range_minimum_segment_tree
   import rmst_pkg::*;
#(
   parameter int LEAVES = LEAVES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [INDEX_WIDTH-1:0]        req_position,
   input  logic [INDEX_WIDTH-1:0]        req_right_end,
   input  logic signed [VALUE_WIDTH-1:0] req_new_value,
   output logic                          rsp_strobe,
   output logic signed [VALUE_WIDTH-1:0] rsp_min_value,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [PADDR_WIDTH-1:0]        paddr,
   input  logic [PDATA_WIDTH-1:0]        pwdata,
   output logic [PDATA_WIDTH-1:0]        prdata,
   output logic                          pready
);

   localparam int DEPTH = 2 * LEAVES;
   localparam int AW = $clog2(DEPTH);
   localparam int IW = $clog2(DEPTH + 1);
   localparam int CW = ($clog2(LEAVES + 1) > COUNT_WIDTH) ? $clog2(LEAVES + 1) : COUNT_WIDTH;

   state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0]        n_used_ff, n_used_in;
   logic [AW-1:0]                 clr_ff, clr_in;
   logic [IW-1:0]                 a_ff, a_in;
   logic [IW-1:0]                 b_ff, b_in;
   logic signed [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic                          have_ff, have_in;
   logic                          pend_ff, pend_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [AW-1:0]          rd_addr;
   logic [VALUE_WIDTH-1:0] rd_data;

   logic [CW-1:0]                 cnt;
   logic [CW-1:0]                 pos_w;
   logic [CW-1:0]                 rgt_w;
   logic [CW-1:0]                 hi_w;
   logic                          accept;
   logic                          query_empty;
   logic                          write_ok;
   logic signed [VALUE_WIDTH-1:0] fold_value;
   logic                          cfg_write;

   rmst_ram #(
      .WIDTH(VALUE_WIDTH),
      .DEPTH(DEPTH)
   ) u_nodes (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign cnt = (CW'(n_used_ff) > CW'(LEAVES)) ? CW'(LEAVES) : CW'(n_used_ff);
   assign pos_w = CW'(req_position);
   assign rgt_w = CW'(req_right_end);
   assign hi_w = (rgt_w >= cnt) ? (cnt - CW'(1)) : rgt_w;
   assign accept = start && !busy;
   assign query_empty = (pos_w >= cnt) || (pos_w > rgt_w);
   assign write_ok = pos_w < cnt;

   // The shared comparator folds the word just read into the running minimum.
   assign fold_value = (!have_ff || ($signed(rd_data) < acc_ff)) ? $signed(rd_data) : acc_ff;

   assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == CSR_N_USED);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  if (write_ok) begin
                     state_in = ST_WR_STEP;
                  end
               end else if (!query_empty) begin
                  state_in = ST_Q_LEFT;
               end
            end
         end
         ST_WR_STEP: begin
            state_in = (a_ff == IW'(1)) ? ST_IDLE : ST_WR_MIN;
         end
         ST_WR_MIN: begin
            state_in = ST_WR_STEP;
         end
         ST_Q_LEFT: begin
            state_in = (a_ff >= b_ff) ? ST_IDLE : ST_Q_RIGHT;
         end
         ST_Q_RIGHT: begin
            state_in = ST_Q_LEFT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      clr_in = clr_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      have_in = have_ff;
      pend_in = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      wr_en = 1'b0;
      wr_addr = a_ff[AW-1:0];
      wr_data = acc_ff;
      rd_addr = a_ff[AW-1:0];
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_op == OP_WRITE) begin
                  a_in = IW'(req_position) + IW'(LEAVES);
                  acc_in = req_new_value;
                  have_in = 1'b1;
               end else if (query_empty) begin
                  rsp_valid_in = 1'b1;
                  rsp_value_in = EMPTY_SENTINEL;
               end else begin
                  a_in = IW'(req_position) + IW'(LEAVES);
                  b_in = IW'(hi_w) + IW'(1) + IW'(LEAVES);
                  have_in = 1'b0;
                  pend_in = 1'b0;
               end
            end
         end
         ST_WR_STEP: begin
            wr_en = 1'b1;
            rd_addr = a_ff[AW-1:0] ^ AW'(1);
         end
         ST_WR_MIN: begin
            acc_in = fold_value;
            a_in = a_ff >> 1;
         end
         ST_Q_LEFT: begin
            if (pend_ff) begin
               acc_in = fold_value;
               have_in = 1'b1;
            end
            if (a_ff >= b_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = pend_ff ? fold_value : acc_ff;
            end else begin
               pend_in = a_ff[0];
               if (a_ff[0]) begin
                  a_in = a_ff + IW'(1);
               end
            end
         end
         ST_Q_RIGHT: begin
            if (pend_ff) begin
               acc_in = fold_value;
               have_in = 1'b1;
            end
            rd_addr = b_ff[AW-1:0] - AW'(1);
            pend_in = b_ff[0];
            a_in = a_ff >> 1;
            b_in = (b_ff[0] ? (b_ff - IW'(1)) : b_ff) >> 1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      n_used_in = n_used_ff;
      if (cfg_write) begin
         n_used_in = pwdata[COUNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         n_used_ff <= N_USED_RESET;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
         have_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         n_used_ff <= n_used_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff <= pend_in;
         have_ff <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_min_value = rsp_value_ff;
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_N_USED) ? PDATA_WIDTH'(n_used_ff) : '0;

endmodule

/* design/rmst_checker.sv */
// Port-level checker for the range minimum segment tree, bound to the top level.
module rmst_checker
   import rmst_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_op,
   input logic                   rsp_strobe,
   input logic                   psel,
   input logic                   penable,
   input logic                   pwrite,
   input logic [PADDR_WIDTH-1:0] paddr,
   input logic [PDATA_WIDTH-1:0] pwdata,
   input logic [PDATA_WIDTH-1:0] prdata,
   input logic                   pready
);

   // The clearing pass keeps the block busy straight after reset.
   assert property (@(posedge clock) reset |=> busy)
      else $error("block not busy after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result word without a request in progress");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_WRITE)) |=> !rsp_strobe)
      else $error("write request produced a result word");

   assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready && (paddr[2] == CSR_N_USED))
      |=> ((paddr[2] != CSR_N_USED)
           || (prdata[COUNT_WIDTH-1:0] == $past(pwdata[COUNT_WIDTH-1:0]))))
      else $error("register read does not return the written word");

   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule

bind range_minimum_segment_tree rmst_checker u_rmst_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_op    (req_op),
   .rsp_strobe(rsp_strobe),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata),
   .pready    (pready)
);

/* tb/sv/range_minimum_segment_tree_tb.sv */
// Self-checking testbench for the range minimum segment tree with point writes.
`timescale 1ns / 1ps

module range_minimum_segment_tree_tb;
   import rmst_pkg::*;

   localparam int ARRAY_SIZE = LEAVES_DEFAULT;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 25;
   localparam int RANDOM_WORDS = 343;
   localparam logic signed [VALUE_WIDTH-1:0] MOST_NEGATIVE = 64'sh8000_0000_0000_0000;
   localparam logic signed [VALUE_WIDTH-1:0] MOST_POSITIVE = 64'sh7fff_ffff_ffff_ffff;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_op = OP_WRITE;
   logic [INDEX_WIDTH-1:0] req_position = '0;
   logic [INDEX_WIDTH-1:0] req_right_end = '0;
   logic signed [VALUE_WIDTH-1:0] req_new_value = '0;
   logic rsp_strobe;
   logic signed [VALUE_WIDTH-1:0] rsp_min_value;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [PADDR_WIDTH-1:0] paddr = '0;
   logic [PDATA_WIDTH-1:0] pwdata = '0;
   logic [PDATA_WIDTH-1:0] prdata;
   logic pready;

   logic signed [VALUE_WIDTH-1:0] shadow_elements [0:ARRAY_SIZE-1];
   logic [COUNT_WIDTH-1:0] shadow_n_used = N_USED_RESET;
   logic signed [VALUE_WIDTH-1:0] pending_minimums [$];
   logic signed [VALUE_WIDTH-1:0] wanted_min;
   int failure_count = 0;
   int stall_cycles = 0;
   int sender_idle_pct = 0;

   range_minimum_segment_tree dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_position(req_position),
      .req_right_end(req_right_end),
      .req_new_value(req_new_value),
      .rsp_strobe(rsp_strobe),
      .rsp_min_value(rsp_min_value),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int covered_count();
      return (shadow_n_used > ARRAY_SIZE) ? ARRAY_SIZE : int'(shadow_n_used);
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] range_minimum(input int lo, input int hi);
      logic signed [VALUE_WIDTH-1:0] least;
      least = shadow_elements[lo];
      for (int i = lo + 1; i <= hi; i++) begin
         if (shadow_elements[i] < least) least = shadow_elements[i];
      end
      return least;
   endfunction

   task automatic apply_to_shadow(input logic op, input logic [INDEX_WIDTH-1:0] pos,
                                  input logic [INDEX_WIDTH-1:0] rgt,
                                  input logic signed [VALUE_WIDTH-1:0] val);
      int cnt;
      int hi;
      cnt = covered_count();
      if (op == OP_WRITE) begin
         if (int'(pos) < cnt) shadow_elements[pos] = val;
      end else if (int'(pos) >= cnt || pos > rgt) begin
         pending_minimums.push_back(EMPTY_SENTINEL);
      end else begin
         hi = (int'(rgt) >= cnt) ? cnt - 1 : int'(rgt);
         pending_minimums.push_back(range_minimum(int'(pos), hi));
      end
   endtask

   task automatic note_failure(input string what, input logic [VALUE_WIDTH-1:0] wanted,
                               input logic [VALUE_WIDTH-1:0] seen);
      failure_count++;
      if (failure_count <= 10)
         $display("%0t: %s: expected %h, got %h", $time, what, wanted, seen);
   endtask

   // The word is left on the bus after acceptance so that a following word can follow at once.
   task automatic send_word(input logic op, input logic [INDEX_WIDTH-1:0] pos,
                            input logic [INDEX_WIDTH-1:0] rgt,
                            input logic signed [VALUE_WIDTH-1:0] val);
      int gap;
      gap = 0;
      if ($urandom_range(99) < sender_idle_pct) gap = $urandom_range(1, 30);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_position <= pos;
      req_right_end <= rgt;
      req_new_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      apply_to_shadow(op, pos, rgt, val);
   endtask

   // A write produces no result, so the block is given time to finish its last walk.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_minimums.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_element_count(input logic [PDATA_WIDTH-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= PADDR_WIDTH'(4 * CSR_N_USED);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      shadow_n_used = value[COUNT_WIDTH-1:0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
      case ($urandom_range(5))
         0: return MOST_POSITIVE - $urandom_range(3);
         1: return MOST_NEGATIVE + $urandom_range(3);
         2: return EMPTY_SENTINEL ^ VALUE_WIDTH'($urandom_range(7));
         3: return VALUE_WIDTH'(int'($urandom_range(2000)) - 1000);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_cleared_store();
      send_word(OP_QUERY, 10'd0, 10'd1023, MOST_POSITIVE);
      send_word(OP_QUERY, 10'd1023, 10'd1023, '0);
   endtask

   task automatic test_extreme_values();
      send_word(OP_WRITE, 10'd0, 10'd1023, MOST_NEGATIVE);
      send_word(OP_WRITE, 10'd1023, 10'd0, MOST_POSITIVE);
      send_word(OP_QUERY, 10'd0, 10'd1023, '0);
      send_word(OP_QUERY, 10'd1, 10'd1023, '0);
      send_word(OP_QUERY, 10'd1023, 10'd1023, '0);
      send_word(OP_QUERY, 10'd5, 10'd3, '0);
   endtask

   task automatic test_large_elements();
      send_word(OP_WRITE, 10'd10, 10'd0, MOST_POSITIVE);
      send_word(OP_WRITE, 10'd11, 10'd0, EMPTY_SENTINEL + 1);
      send_word(OP_WRITE, 10'd12, 10'd0, EMPTY_SENTINEL + 5);
      send_word(OP_QUERY, 10'd10, 10'd12, '0);
      send_word(OP_QUERY, 10'd12, 10'd12, '0);
   endtask

   task automatic test_register_settings();
      drain_results();
      write_element_count(32'd1);
      send_word(OP_WRITE, 10'd1, 10'd0, 64'sd7);
      send_word(OP_QUERY, 10'd0, 10'd1023, '0);
      send_word(OP_QUERY, 10'd1, 10'd1, '0);
      drain_results();
      write_element_count(32'd0);
      send_word(OP_WRITE, 10'd0, 10'd0, 64'sd9);
      send_word(OP_QUERY, 10'd0, 10'd0, '0);
      drain_results();
      write_element_count(32'd2047);
      send_word(OP_WRITE, 10'd1, 10'd0, -64'sd3);
      send_word(OP_QUERY, 10'd1, 10'd1023, '0);
      send_word(OP_QUERY, 10'd0, 10'd1023, '0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input logic [PDATA_WIDTH-1:0] count_word);
      int done;
      int cnt;
      int pick;
      logic op;
      logic [INDEX_WIDTH-1:0] pos;
      logic [INDEX_WIDTH-1:0] rgt;
      drain_results();
      write_element_count(count_word);
      sender_idle_pct = idle_pct;
      cnt = covered_count();
      done = 0;
      while (done < RANDOM_WORDS) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            op = OP_WRITE;
            pos = INDEX_WIDTH'($urandom_range(cnt - 1));
            rgt = INDEX_WIDTH'($urandom);
         end else if (pick < 90) begin
            op = OP_QUERY;
            pos = INDEX_WIDTH'($urandom_range(cnt - 1));
            if ($urandom_range(3) == 0)
               rgt = INDEX_WIDTH'($urandom_range(ARRAY_SIZE - 1, int'(pos)));
            else if (int'(pos) + 15 >= ARRAY_SIZE)
               rgt = INDEX_WIDTH'(ARRAY_SIZE - 1);
            else
               rgt = INDEX_WIDTH'(int'(pos) + $urandom_range(15));
         end else begin
            op = 1'($urandom_range(1));
            pos = INDEX_WIDTH'($urandom);
            rgt = INDEX_WIDTH'($urandom);
         end
         send_word(op, pos, rgt, pick_value());
         if (!(op == OP_WRITE && int'(pos) >= cnt)) done++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_minimums.size() == 0) begin
            note_failure("minimum with no query pending", 'x, rsp_min_value);
         end else begin
            wanted_min = pending_minimums.pop_front();
            if (rsp_min_value !== wanted_min)
               note_failure("min_value mismatch", wanted_min, rsp_min_value);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("range_minimum_segment_tree test failed");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < ARRAY_SIZE; i++) shadow_elements[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 19;
      test_cleared_store();
      test_extreme_values();
      test_large_elements();
      test_register_settings();
      test_random_traffic(19, 32'd1024);
      test_random_traffic(55, PDATA_WIDTH'($urandom_range(1023, 2)));
      test_random_traffic(0, {21'($urandom_range(2097151)), 11'($urandom_range(2047, 1025))});
      drain_results();
      if (failure_count == 0)
         $display("range_minimum_segment_tree test passed");
      else
         $display("range_minimum_segment_tree test failed");
      $finish;
   end

endmodule

/* filelist.f */
design/rmst_pkg.sv
design/rmst_ram.sv
design/range_minimum_segment_tree.sv
design/rmst_checker.sv
tb/sv/range_minimum_segment_tree_tb.sv
